FILE: sv/grhp_pkg.sv
// grhp_pkg: shared constants, result type and word helpers for the
// request header parser; no dependencies
`timescale 1ns / 1ps

package grhp_pkg;

  localparam int MAX_MESSAGE_BYTES = 8192;
  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int OP_W = 14;

  localparam logic [31:0] BYTE0_MASK = 32'h0000_00FF;
  localparam logic [31:0] BYTE1_MASK = 32'h0000_FF00;
  localparam logic [31:0] BYTE2_MASK = 32'h00FF_0000;
  localparam logic [31:0] BYTE3_MASK = 32'hFF00_0000;
  localparam logic [31:0] PAD_LIMIT = 32'hFFFF_FFFC;

  typedef enum logic [1:0] {
    KIND_KEY_BYTE = 2'd0,
    KIND_HEADER   = 2'd1,
    KIND_TRUNC    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       key_byte;
    logic [31:0]      call_id;
    logic [31:0]      key_length;
    logic [OP_W-1:0]  operation_offset;
  } result_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = ((v & BYTE0_MASK) << 24) | ((v & BYTE1_MASK) << 8) |
             ((v & BYTE2_MASK) >> 8) | ((v & BYTE3_MASK) >> 24);
  endfunction

  function automatic logic [31:0] pad4(input logic [31:0] len);
    if (len > PAD_LIMIT) begin
      pad4 = PAD_LIMIT;
    end else begin
      pad4 = (len + 32'd3) & PAD_LIMIT;
    end
  endfunction

endpackage

FILE: sv/grhp_parse.sv
// grhp_parse: per-beat header walk, state registers and result formation
// depends on grhp_pkg
`timescale 1ns / 1ps

module grhp_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   beat,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   result_valid,
  output grhp_pkg::result_t      result
);

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_CTX_COUNT = 4'd1,
    PH_CTX_ID    = 4'd2,
    PH_CTX_LEN   = 4'd3,
    PH_CTX_DATA  = 4'd4,
    PH_REQ_ID    = 4'd5,
    PH_RESPONSE  = 4'd6,
    PH_KEY_LEN   = 4'd7,
    PH_KEY       = 4'd8,
    PH_DONE      = 4'd9,
    PH_DROP      = 4'd10
  } phase_t;

  logic [grhp_pkg::OFF_W-1:0] byte_offset, byte_offset_next;
  phase_t                     parse_phase, parse_phase_next;
  logic                       little_order, little_order_next;
  logic [31:0]                word_accumulator, word_accumulator_next;
  logic [1:0]                 word_byte_count, word_byte_count_next;
  logic [31:0]                contexts_left, contexts_left_next;
  logic [31:0]                skip_left, skip_left_next;
  logic [31:0]                key_left, key_left_next;
  logic [31:0]                held_call_id, held_call_id_next;
  logic [31:0]                held_key_length, held_key_length_next;

  logic [31:0]                acc_shift;
  logic                       word_done;
  logic [31:0]                word_val;
  logic [31:0]                ctx_dec;
  logic [31:0]                skip_dec;
  logic [31:0]                len_pad;
  logic [grhp_pkg::OFF_W:0]   off_inc;
  logic                       finished;
  logic                       is_key;
  logic                       overlong;
  logic                       active;

  assign acc_shift = {word_accumulator[23:0], data_byte};
  assign word_done = (word_byte_count == 2'd3);
  assign word_val  = little_order ? grhp_pkg::swap32(acc_shift) : acc_shift;
  assign ctx_dec   = contexts_left - 32'd1;
  assign skip_dec  = skip_left - 32'd1;
  assign len_pad   = grhp_pkg::pad4(word_val);
  assign off_inc   = {1'b0, byte_offset} + 1'b1;
  assign active    = (parse_phase != PH_DONE) && (parse_phase != PH_DROP);
  assign overlong  = active &&
                     (byte_offset >= grhp_pkg::OFF_W'(grhp_pkg::MAX_MESSAGE_BYTES));

  always_comb begin
    byte_offset_next      = byte_offset;
    parse_phase_next      = parse_phase;
    little_order_next     = little_order;
    word_accumulator_next = word_accumulator;
    word_byte_count_next  = word_byte_count;
    contexts_left_next    = contexts_left;
    skip_left_next        = skip_left;
    key_left_next         = key_left;
    held_call_id_next     = held_call_id;
    held_key_length_next  = held_key_length;
    finished              = 1'b0;
    is_key                = 1'b0;

    if (beat && active) begin
      if (overlong) begin
        parse_phase_next = PH_DROP;
      end else begin
        byte_offset_next = off_inc[grhp_pkg::OFF_W-1:0];
        if ((parse_phase != PH_HEADER) && (parse_phase != PH_CTX_DATA) &&
            (parse_phase != PH_KEY)) begin
          word_accumulator_next = word_done ? 32'd0 : acc_shift;
          word_byte_count_next  = word_byte_count + 2'd1;
        end
        unique case (parse_phase)
          PH_HEADER: begin
            if (byte_offset == grhp_pkg::OFF_W'(6)) begin
              little_order_next = data_byte[0];
            end
            if (byte_offset >= grhp_pkg::OFF_W'(11)) begin
              parse_phase_next      = PH_CTX_COUNT;
              word_accumulator_next = 32'd0;
              word_byte_count_next  = 2'd0;
            end
          end
          PH_CTX_COUNT: begin
            if (word_done) begin
              contexts_left_next = word_val;
              parse_phase_next   = (word_val != 32'd0) ? PH_CTX_ID : PH_REQ_ID;
            end
          end
          PH_CTX_ID: begin
            if (word_done) begin
              parse_phase_next = PH_CTX_LEN;
            end
          end
          PH_CTX_LEN: begin
            if (word_done) begin
              skip_left_next = len_pad;
              if (len_pad == 32'd0) begin
                contexts_left_next = ctx_dec;
                parse_phase_next   = (ctx_dec != 32'd0) ? PH_CTX_ID : PH_REQ_ID;
              end else begin
                parse_phase_next = PH_CTX_DATA;
              end
            end
          end
          PH_CTX_DATA: begin
            skip_left_next = skip_dec;
            if (skip_dec == 32'd0) begin
              contexts_left_next = ctx_dec;
              parse_phase_next   = (ctx_dec != 32'd0) ? PH_CTX_ID : PH_REQ_ID;
            end
          end
          PH_REQ_ID: begin
            if (word_done) begin
              held_call_id_next = word_val;
              parse_phase_next  = PH_RESPONSE;
            end
          end
          PH_RESPONSE: begin
            if (word_done) begin
              parse_phase_next = PH_KEY_LEN;
            end
          end
          PH_KEY_LEN: begin
            if (word_done) begin
              held_key_length_next = word_val;
              key_left_next        = word_val;
              skip_left_next       = len_pad;
              if (len_pad == 32'd0) begin
                parse_phase_next = PH_DONE;
                finished         = 1'b1;
              end else begin
                parse_phase_next = PH_KEY;
              end
            end
          end
          PH_KEY: begin
            is_key         = (key_left != 32'd0);
            key_left_next  = is_key ? key_left - 32'd1 : key_left;
            skip_left_next = skip_dec;
            if (skip_dec == 32'd0) begin
              parse_phase_next = PH_DONE;
              finished         = 1'b1;
            end
          end
          default: begin
            parse_phase_next = PH_DROP;
          end
        endcase
      end
    end

    if (beat && last_byte) begin
      byte_offset_next      = '0;
      parse_phase_next      = PH_HEADER;
      little_order_next     = 1'b0;
      word_accumulator_next = 32'd0;
      word_byte_count_next  = 2'd0;
      contexts_left_next    = 32'd0;
      skip_left_next        = 32'd0;
      key_left_next         = 32'd0;
      held_call_id_next     = 32'd0;
      held_key_length_next  = 32'd0;
    end
  end

  // result selection for this beat
  always_comb begin
    result.kind             = grhp_pkg::KIND_TRUNC;
    result.key_byte         = 8'd0;
    result.call_id          = 32'd0;
    result.key_length       = 32'd0;
    result.operation_offset = '0;
    result_valid            = 1'b0;
    if (beat && active) begin
      if (overlong) begin
        result_valid = 1'b1;
      end else if (finished) begin
        result_valid            = 1'b1;
        result.kind             = grhp_pkg::KIND_HEADER;
        result.key_byte         = is_key ? data_byte : 8'd0;
        result.call_id          = held_call_id;
        result.key_length       = held_key_length;
        result.operation_offset = grhp_pkg::OP_W'(off_inc);
      end else if (last_byte) begin
        result_valid = 1'b1;
      end else if (is_key) begin
        result_valid      = 1'b1;
        result.kind       = grhp_pkg::KIND_KEY_BYTE;
        result.key_byte   = data_byte;
        result.call_id    = held_call_id;
        result.key_length = held_key_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      parse_phase      <= PH_HEADER;
      little_order     <= 1'b0;
      word_accumulator <= 32'd0;
      word_byte_count  <= 2'd0;
      contexts_left    <= 32'd0;
      skip_left        <= 32'd0;
      key_left         <= 32'd0;
      held_call_id     <= 32'd0;
      held_key_length  <= 32'd0;
    end else begin
      byte_offset      <= byte_offset_next;
      parse_phase      <= parse_phase_next;
      little_order     <= little_order_next;
      word_accumulator <= word_accumulator_next;
      word_byte_count  <= word_byte_count_next;
      contexts_left    <= contexts_left_next;
      skip_left        <= skip_left_next;
      key_left         <= key_left_next;
      held_call_id     <= held_call_id_next;
      held_key_length  <= held_key_length_next;
    end
  end

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    byte_offset <= grhp_pkg::OFF_W'(grhp_pkg::MAX_MESSAGE_BYTES))
    else $error("byte offset beyond message limit");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (beat && last_byte) |=> (parse_phase == PH_HEADER) && (byte_offset == '0))
    else $error("parser did not restart after final beat");

  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_CTX_DATA || parse_phase == PH_KEY || parse_phase == PH_DONE)
      |-> (word_byte_count == 2'd0))
    else $error("word assembly left partial in a byte phase");

  a_key_within_pad: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_KEY) |-> (skip_left != 32'd0))
    else $error("key phase with nothing left to skip");

endmodule

FILE: sv/grhp_out_stage.sv
// grhp_out_stage: result register with one skid entry
// depends on grhp_pkg
`timescale 1ns / 1ps

module grhp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  grhp_pkg::result_t   push_data,
  output logic                full,
  output logic                res_valid,
  input  logic                res_stall,
  output grhp_pkg::result_t   res_data
);

  logic              skid_valid;
  grhp_pkg::result_t skid_data;
  logic              head_free;

  assign head_free = !res_valid || !res_stall;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        res_data   <= skid_data;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_data  <= push_data;
        res_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed into full output stage");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !res_stall) |=> !skid_valid)
    else $error("skid entry not drained after a taken beat");

endmodule

FILE: sv/giop_request_header_parser.sv
// giop_request_header_parser: top level, byte stream in, key bytes and
// header status out; depends on grhp_pkg, grhp_parse, grhp_out_stage
//
//   channel  handshake            payload
//   req      req_valid/req_stall  data_byte, last_byte
//   res      res_valid/res_stall  kind, key_byte, call_id, key_length,
//                                 operation_offset
//
// one byte per cycle sustained while req_stall is low; the parser state updates
// on each accepted beat and its result is registered in the output stage
// rst is synchronous and returns the parser to the start of a message
// a result stall is absorbed by one skid entry; req_stall rises only
// while that entry is occupied
`timescale 1ns / 1ps

module giop_request_header_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [1:0]                kind,
  output logic [7:0]                key_byte,
  output logic [31:0]               call_id,
  output logic [31:0]               key_length,
  output logic [grhp_pkg::OP_W-1:0] operation_offset
);

  logic              beat;
  logic              push;
  logic              full;
  grhp_pkg::result_t step_result;
  grhp_pkg::result_t res_data;

  assign req_stall = full;
  assign beat      = req_valid && !full;

  grhp_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (push),
    .result       (step_result)
  );

  grhp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (step_result),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  assign kind             = res_data.kind;
  assign key_byte         = res_data.key_byte;
  assign call_id          = res_data.call_id;
  assign key_length       = res_data.key_length;
  assign operation_offset = res_data.operation_offset;

endmodule

FILE: sim/grhp_stream_watch.sv
// grhp_stream_watch: watches both channels of the request header parser,
// tracks the parse of each message byte by byte and compares every result beat
// depends on grhp_pkg for the result layout and kind codes
`timescale 1ns / 1ps

module grhp_stream_watch (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_stall,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic                      res_valid,
  input  logic                      res_stall,
  input  logic [1:0]                kind,
  input  logic [7:0]                key_byte,
  input  logic [31:0]               call_id,
  input  logic [31:0]               key_length,
  input  logic [grhp_pkg::OP_W-1:0] operation_offset,
  output int                        open_results,
  output int                        mismatches
);

  typedef enum logic [3:0] {
    ST_HEADER,
    ST_CTX_COUNT,
    ST_CTX_ID,
    ST_CTX_LEN,
    ST_CTX_DATA,
    ST_REQ_ID,
    ST_RESPONSE,
    ST_KEY_LEN,
    ST_KEY,
    ST_DONE,
    ST_DROP
  } walk_t;

  walk_t       phase;
  int unsigned msg_offset;
  bit          little;
  logic [31:0] acc;
  logic [1:0]  acc_cnt;
  logic [31:0] ctx_left;
  logic [31:0] skip_left;
  logic [31:0] rid_held;
  logic [31:0] klen_held;

  grhp_pkg::result_t header_results_q[$];
  grhp_pkg::result_t fresh;
  grhp_pkg::result_t due;
  bit                have;
  int                bad_fields = 0;

  task automatic clear_message();
    phase      = ST_HEADER;
    msg_offset = 0;
    little     = 1'b0;
    acc        = '0;
    acc_cnt    = '0;
    ctx_left   = '0;
    skip_left  = '0;
    rid_held   = '0;
    klen_held  = '0;
  endtask

  function automatic logic [31:0] round_up4(input logic [31:0] len);
    if (len > 32'hFFFF_FFFC) begin
      return 32'hFFFF_FFFC;
    end
    return (len + 32'd3) & ~32'd3;
  endfunction

  task automatic shift_in(input logic [7:0] b, output bit full, output logic [31:0] w);
    acc = {acc[23:0], b};
    full = 1'b0;
    w = '0;
    if (acc_cnt == 2'd3) begin
      acc_cnt = '0;
      w = little ? {acc[7:0], acc[15:8], acc[23:16], acc[31:24]} : acc;
      acc = '0;
      full = 1'b1;
    end else begin
      acc_cnt = acc_cnt + 2'd1;
    end
  endtask

  task automatic close_context();
    ctx_left = ctx_left - 32'd1;
    phase = (ctx_left != 0) ? ST_CTX_ID : ST_REQ_ID;
  endtask

  task automatic take_beat(input logic [7:0] b, input bit last, output bit got,
                           output grhp_pkg::result_t r);
    int unsigned off;
    logic [31:0] w;
    bit          full;
    bit          finished;
    bit          is_key;
    got = 1'b0;
    r = '0;
    finished = 1'b0;
    is_key = 1'b0;
    if (phase == ST_DONE || phase == ST_DROP) begin
      if (last) clear_message();
      return;
    end
    off = msg_offset;
    if (off >= grhp_pkg::MAX_MESSAGE_BYTES) begin
      got = 1'b1;
      r.kind = grhp_pkg::KIND_TRUNC;
      phase = ST_DROP;
      if (last) clear_message();
      return;
    end
    msg_offset = off + 1;
    case (phase)
      ST_HEADER: begin
        if (off == 6) little = b[0];
        if (off >= 11) begin
          phase = ST_CTX_COUNT;
          acc = '0;
          acc_cnt = '0;
        end
      end
      ST_CTX_COUNT: begin
        shift_in(b, full, w);
        if (full) begin
          ctx_left = w;
          phase = (w != 0) ? ST_CTX_ID : ST_REQ_ID;
        end
      end
      ST_CTX_ID: begin
        shift_in(b, full, w);
        if (full) phase = ST_CTX_LEN;
      end
      ST_CTX_LEN: begin
        shift_in(b, full, w);
        if (full) begin
          skip_left = round_up4(w);
          if (skip_left == 0) close_context();
          else phase = ST_CTX_DATA;
        end
      end
      ST_CTX_DATA: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) close_context();
      end
      ST_REQ_ID: begin
        shift_in(b, full, w);
        if (full) begin
          rid_held = w;
          phase = ST_RESPONSE;
        end
      end
      ST_RESPONSE: begin
        shift_in(b, full, w);
        if (full) phase = ST_KEY_LEN;
      end
      ST_KEY_LEN: begin
        shift_in(b, full, w);
        if (full) begin
          klen_held = w;
          skip_left = round_up4(w);
          if (skip_left == 0) begin
            phase = ST_DONE;
            finished = 1'b1;
          end else begin
            phase = ST_KEY;
          end
        end
      end
      ST_KEY: begin
        is_key = (round_up4(klen_held) - skip_left) < klen_held;
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) begin
          phase = ST_DONE;
          finished = 1'b1;
        end
      end
      default: begin
        phase = ST_DROP;
      end
    endcase
    if (finished) begin
      got = 1'b1;
      r.kind = grhp_pkg::KIND_HEADER;
      r.key_byte = is_key ? b : 8'd0;
      r.call_id = rid_held;
      r.key_length = klen_held;
      r.operation_offset = grhp_pkg::OP_W'(off + 1);
    end else if (last) begin
      got = 1'b1;
      r.kind = grhp_pkg::KIND_TRUNC;
    end else if (is_key) begin
      got = 1'b1;
      r.kind = grhp_pkg::KIND_KEY_BYTE;
      r.key_byte = b;
      r.call_id = rid_held;
      r.key_length = klen_held;
    end
    if (last) clear_message();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      header_results_q.delete();
    end else begin
      if (req_valid && !req_stall) begin
        take_beat(data_byte, last_byte, have, fresh);
        if (have) header_results_q.push_back(fresh);
      end
      if (res_valid && !res_stall) begin
        if (header_results_q.size() == 0) begin
          $error("result beat with nothing expected, kind %0d", kind);
          bad_fields++;
        end else begin
          due = header_results_q.pop_front();
          if (kind !== due.kind) begin
            $error("kind: expected %0d, actual %0d", due.kind, kind);
            bad_fields++;
          end
          if (key_byte !== due.key_byte) begin
            $error("key_byte: expected %0h, actual %0h", due.key_byte, key_byte);
            bad_fields++;
          end
          if (call_id !== due.call_id) begin
            $error("call_id: expected %0h, actual %0h", due.call_id, call_id);
            bad_fields++;
          end
          if (key_length !== due.key_length) begin
            $error("key_length: expected %0h, actual %0h", due.key_length, key_length);
            bad_fields++;
          end
          if (operation_offset !== due.operation_offset) begin
            $error("operation_offset: expected %0d, actual %0d", due.operation_offset,
                   operation_offset);
            bad_fields++;
          end
        end
      end
    end
    open_results <= header_results_q.size();
    mismatches <= bad_fields;
  end

endmodule

FILE: sim/giop_request_header_parser_test.sv
// giop_request_header_parser_test: drives request messages byte by byte into
// the header parser with random gaps and result stalls, and gives the verdict
// depends on grhp_pkg, giop_request_header_parser and grhp_stream_watch
`timescale 1ns / 1ps

module giop_request_header_parser_test;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic [7:0]                    data_byte = '0;
  logic                          last_byte = 1'b0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  logic [1:0]                    kind;
  logic [7:0]                    key_byte;
  logic [31:0]                   call_id;
  logic [31:0]                   key_length;
  logic [grhp_pkg::OP_W-1:0]     operation_offset;

  int                  open_results;
  int                  mismatches;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  sent_beats = 0;
  logic [7:0]          msg_bytes[$];

  giop_request_header_parser u_dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .kind             (kind),
    .key_byte         (key_byte),
    .call_id          (call_id),
    .key_length       (key_length),
    .operation_offset (operation_offset)
  );

  grhp_stream_watch u_watch (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .kind             (kind),
    .key_byte         (key_byte),
    .call_id          (call_id),
    .key_length       (key_length),
    .operation_offset (operation_offset),
    .open_results     (open_results),
    .mismatches       (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic put_random(input int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endtask

  task automatic put_word(input logic [31:0] v, input bit le);
    if (le) begin
      msg_bytes.push_back(v[7:0]);
      msg_bytes.push_back(v[15:8]);
      msg_bytes.push_back(v[23:16]);
      msg_bytes.push_back(v[31:24]);
    end else begin
      msg_bytes.push_back(v[31:24]);
      msg_bytes.push_back(v[23:16]);
      msg_bytes.push_back(v[15:8]);
      msg_bytes.push_back(v[7:0]);
    end
  endtask

  // lengths above cap get cap bytes of body and the message stops there
  task automatic build_message(input bit le, input logic [31:0] n_ctx,
                               input logic [31:0] first_len, input logic [31:0] rid,
                               input logic [31:0] key_len, input int tail, input int cap);
    int          c;
    logic [31:0] clen;
    msg_bytes.delete();
    put_random(6);
    msg_bytes.push_back({7'($urandom), le});
    put_random(5);
    put_word(n_ctx, le);
    for (c = 0; c < 4 && c < n_ctx; c++) begin
      clen = (c == 0) ? first_len : 32'($urandom_range(0, 9));
      put_word($urandom, le);
      put_word(clen, le);
      if (clen > cap) begin
        put_random(cap);
        return;
      end
      put_random((clen + 32'd3) & ~32'd3);
    end
    if (n_ctx > 4) return;
    put_word(rid, le);
    put_word($urandom, le);
    put_word(key_len, le);
    if (key_len > cap) begin
      put_random(cap);
      return;
    end
    put_random((key_len + 32'd3) & ~32'd3);
    put_random(tail);
  endtask

  task automatic cut_message();
    int cut;
    if (msg_bytes.size() > 1) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) msg_bytes.delete(msg_bytes.size() - 1);
    end
  endtask

  task automatic random_message();
    int          pick;
    bit          le;
    logic [31:0] klen;
    pick = $urandom_range(0, 99);
    le = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: klen = 32'd0;
      1: klen = 32'd4;
      2: klen = 32'd8;
      default: klen = $urandom_range(1, 12);
    endcase
    if (pick < 80) begin
      build_message(le, $urandom_range(0, 3), $urandom_range(0, 9), $urandom, klen,
                    $urandom_range(0, 6), 64);
      if (pick >= 66) cut_message();
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: build_message(le, 32'hFFFF_FFF0 | $urandom_range(0, 15), $urandom_range(0, 9),
                         $urandom, klen, 0, 64);
        1: build_message(le, 1, 32'hFFFF_FFF8 + $urandom_range(0, 7), $urandom, klen, 0, 64);
        2: build_message(le, 0, 0, $urandom, 32'hFFFF_FFF8 + $urandom_range(0, 7), 0, 64);
        default: build_message(le, 0, 0, $urandom, $urandom_range(13, 300), 0, 64);
      endcase
    end else begin
      msg_bytes.delete();
      put_random($urandom_range(1, 40));
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) begin
      send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    sent_beats += msg_bytes.size();
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int mode;
    int base;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_stall_pct = 46;
    // one-byte messages end inside the fixed header
    msg_bytes.delete();
    msg_bytes.push_back(8'hFF);
    send_message();
    msg_bytes.delete();
    msg_bytes.push_back(8'h00);
    send_message();
    // little-endian, empty context, key of 4 ends the header on its last byte
    build_message(1'b1, 1, 0, 32'hFFFF_FFFF, 4, 0, 64);
    send_message();
    // big-endian, empty key, bytes after the header
    build_message(1'b0, 0, 0, 32'h0000_0000, 0, 3, 64);
    send_message();
    // message ends on a key byte
    build_message(1'b0, 0, 0, 32'h8000_0001, 6, 0, 64);
    while (msg_bytes.size() > 30) msg_bytes.delete(msg_bytes.size() - 1);
    send_message();

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 9;
          recv_stall_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      base = sent_beats;
      while (sent_beats - base < 400) begin
        random_message();
        send_message();
      end
      hold_until_drained();
    end

    req_valid <= 1'b0;
    while (open_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && open_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/grhp_pkg.sv
sv/grhp_parse.sv
sv/grhp_out_stage.sv
sv/giop_request_header_parser.sv
sim/grhp_stream_watch.sv
sim/giop_request_header_parser_test.sv
